// ===== hdl/ttsch_pkg.sv =====
// Shared types and constants for the timer table scheduler.
// No dependencies; imported by the controller, datapath and top level.
package ttsch_pkg;

  localparam int TIME_W     = 63;  // microsecond times and intervals
  localparam int DL_W       = 55;  // signed millisecond deadline
  localparam int ID_W       = 4;   // reported slot number
  localparam int RESULT_CAP = 16;  // most timers fired by one schedule word
  localparam int FIRE_CNT_W = 5;
  localparam logic [10:0] US_PER_MS = 11'd1000;

  // divide by 1000 one 16-bit digit at a time: multiply phase, then digit phase
  localparam int DIV_DIGIT_W = 16;
  localparam int DIV_Q_W     = TIME_W + 1;  // dividend padded to whole digits
  localparam int DIV_STEPS   = DIV_Q_W / DIV_DIGIT_W;
  localparam int DIV_CNT_W   = 3;
  localparam int DIV_REM_W   = 10;
  localparam int DIV_TRIAL_W = DIV_REM_W + DIV_DIGIT_W;
  localparam int RECIP_SHIFT = 36;
  localparam int DIV_PROD_W  = DIV_TRIAL_W + 27;
  // ceil(2^36 / 1000); quotient is exact for any trial below 2^26
  localparam logic [26:0] RECIP_MS = 27'd68719477;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_SCHED  = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FIRED     = 3'd3,
    ST_NONE_DUE  = 3'd4
  } rsp_status_t;

  typedef enum logic [1:0] {
    SCAN_FREE,       // first free slot
    SCAN_DUE_FIRST,  // mark due slots, earliest due
    SCAN_DUE,        // earliest among still-marked slots
    SCAN_MIN         // earliest valid slot
  } scan_mode_t;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_BEST,
    ID_TID
  } id_sel_t;

  typedef enum logic [1:0] {
    DL_ZERO,
    DL_EMPTY,
    DL_QUOT
  } dl_sel_t;

  typedef struct packed {
    logic        load;
    logic        scan_start;
    scan_mode_t  scan_mode;
    logic        add_commit;
    logic        cancel_commit;
    logic        fire_commit;
    logic        div_start;
    logic        emit;
    rsp_status_t res_status;
    id_sel_t     res_id;
    dl_sel_t     res_dl;
    logic        res_last;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic min_due;
    logic last_fire;
    logic cancel_hit;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/ttsch_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ttsch_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ttsch_dp.sv =====
// Datapath: slot valid/due flags, expiration and interval RAMs, slot scanner,
// millisecond divider and result register. Depends on ttsch_pkg, ttsch_ram.
module ttsch_dp #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ttsch_pkg::cmd_t               cmd,
  output ttsch_pkg::stat_t              stat,
  input  logic [ttsch_pkg::ID_W-1:0]    slot_id,
  input  logic [ttsch_pkg::TIME_W-1:0]  when,
  input  logic [ttsch_pkg::TIME_W-1:0]  interval,
  input  logic [ttsch_pkg::TIME_W-1:0]  now,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [2:0]                    status,
  output logic [ttsch_pkg::ID_W-1:0]    timer_id_res,
  output logic signed [ttsch_pkg::DL_W-1:0] deadline_ms,
  output logic                          last
);
  import ttsch_pkg::*;

  localparam int SW = $clog2(MAX_TIMERS);
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam logic [SW-1:0]   LAST_IDX = SW'(MAX_TIMERS - 1);
  localparam logic [SW+3:0]   NUM_SLOTS = (SW + 4)'(MAX_TIMERS);

  logic [MAX_TIMERS-1:0] vld;
  logic [MAX_TIMERS-1:0] due;

  logic [ID_W-1:0]   tid_r;
  logic [TIME_W-1:0] when_r;
  logic [TIME_W-1:0] ivl_r;
  logic [TIME_W-1:0] now_r;

  logic              scan_busy;
  logic [SW-1:0]     scan_cnt;
  scan_mode_t        scan_mode_r;
  logic              rd_pend;
  logic [SW-1:0]     rd_idx;
  logic              found;
  logic [SW-1:0]     best_idx;
  logic [TIME_W-1:0] best_exp;
  logic [CW-1:0]     due_cnt;
  logic [FIRE_CNT_W-1:0] fire_cnt;

  logic                   div_busy;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [DIV_Q_W-1:0]     div_q;
  logic [DIV_REM_W-1:0]   div_rem;
  logic [DIV_TRIAL_W-1:0] div_trial;
  logic [DIV_PROD_W-1:0]  div_prod;
  logic [DIV_DIGIT_W-1:0] div_digit;
  logic [DIV_TRIAL_W-1:0] div_back;

  logic [SW-1:0]     raddr;
  logic [TIME_W-1:0] exp_rd;
  logic [TIME_W-1:0] ivl_rd;
  logic              exp_we;
  logic [TIME_W-1:0] exp_wdata;
  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm;
  logic              ivl_nz;

  logic              exp_le_now;
  logic              cand;
  logic              take;
  logic              mark_due;

  logic [SW+3:0]     tid_w;
  logic [SW-1:0]     tid_idx;
  logic [SW+3:0]     best_w;

  rsp_status_t       status_r;

  // ---------------------------------------------------------------- RAMs
  assign raddr = scan_busy ? scan_cnt : best_idx;

  assign rearm_sum = {1'b0, now_r} + {1'b0, ivl_rd};
  assign rearm     = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];
  assign ivl_nz    = (ivl_rd != '0);
  assign exp_we    = cmd.add_commit || (cmd.fire_commit && ivl_nz);
  assign exp_wdata = cmd.add_commit ? when_r : rearm;

  ttsch_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TIMERS)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (best_idx),
    .wdata (exp_wdata),
    .raddr (raddr),
    .rdata (exp_rd)
  );

  ttsch_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TIMERS)) u_ivl_ram (
    .clk   (clk),
    .we    (cmd.add_commit),
    .waddr (best_idx),
    .wdata (ivl_r),
    .raddr (raddr),
    .rdata (ivl_rd)
  );

  // ---------------------------------------------------------------- scan compare
  assign exp_le_now = (exp_rd <= now_r);
  assign mark_due   = vld[rd_idx] && exp_le_now;

  always_comb begin
    case (scan_mode_r)
      SCAN_FREE:      cand = !vld[rd_idx] && !found;
      SCAN_DUE_FIRST: cand = mark_due;
      SCAN_DUE:       cand = due[rd_idx];
      SCAN_MIN:       cand = vld[rd_idx];
      default:        cand = 1'b0;
    endcase
  end

  // strict less-than keeps the lower slot on a tie
  assign take = rd_pend && cand &&
                ((scan_mode_r == SCAN_FREE) || !found || (exp_rd < best_exp));

  assign tid_w   = (SW + 4)'(tid_r);
  assign tid_idx = tid_w[SW-1:0];
  assign best_w  = (SW + 4)'(best_idx);

  // ---------------------------------------------------------------- divider step
  // remainder stays below 1000, so each quotient digit fits in 16 bits
  assign div_trial = {div_rem, div_q[DIV_Q_W-1 -: DIV_DIGIT_W]};
  assign div_digit = div_prod[RECIP_SHIFT +: DIV_DIGIT_W];
  assign div_back  = DIV_TRIAL_W'(div_digit) * DIV_TRIAL_W'(US_PER_MS);

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      due       <= '0;
      scan_busy <= 1'b0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      due_cnt   <= '0;
      fire_cnt  <= '0;
      div_busy  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend <= scan_busy;

      if (cmd.scan_start) begin
        scan_busy <= 1'b1;
        found     <= 1'b0;
        if (cmd.scan_mode == SCAN_DUE_FIRST) begin
          due_cnt  <= '0;
          fire_cnt <= '0;
        end
      end else if (scan_busy && (scan_cnt == LAST_IDX)) begin
        scan_busy <= 1'b0;
      end

      if (take) begin
        found <= 1'b1;
      end

      if (rd_pend && (scan_mode_r == SCAN_DUE_FIRST)) begin
        due[rd_idx] <= mark_due;
        due_cnt     <= due_cnt + CW'(mark_due);
      end

      if (cmd.add_commit) begin
        vld[best_idx] <= 1'b1;
      end
      if (cmd.cancel_commit) begin
        vld[tid_idx] <= 1'b0;
      end
      if (cmd.fire_commit) begin
        due[best_idx] <= 1'b0;
        fire_cnt      <= fire_cnt + FIRE_CNT_W'(1);
        if (!ivl_nz) begin
          vld[best_idx] <= 1'b0;
        end
      end

      if (cmd.div_start) begin
        div_busy <= 1'b1;
      end else if (div_busy && (div_cnt == DIV_CNT_W'(2 * DIV_STEPS - 1))) begin
        div_busy <= 1'b0;
      end

      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tid_r  <= slot_id;
      when_r <= when;
      ivl_r  <= interval;
      now_r  <= now;
    end

    if (cmd.scan_start) begin
      scan_cnt    <= '0;
      scan_mode_r <= cmd.scan_mode;
    end else if (scan_busy) begin
      scan_cnt <= scan_cnt + SW'(1);
    end
    rd_idx <= scan_cnt;

    if (take) begin
      best_idx <= rd_idx;
      best_exp <= exp_rd;
    end

    if (cmd.div_start) begin
      div_q   <= {1'b0, best_exp - now_r};
      div_rem <= '0;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (!div_cnt[0]) begin
        div_prod <= DIV_PROD_W'(div_trial) * DIV_PROD_W'(RECIP_MS);
      end else begin
        div_rem <= DIV_REM_W'(div_trial - div_back);
        div_q   <= {div_q[DIV_Q_W-DIV_DIGIT_W-1:0], div_digit};
      end
    end

    if (cmd.emit) begin
      status_r <= cmd.res_status;
      last     <= cmd.res_last;
      case (cmd.res_id)
        ID_BEST: timer_id_res <= best_w[ID_W-1:0];
        ID_TID:  timer_id_res <= tid_r;
        default: timer_id_res <= '0;
      endcase
      case (cmd.res_dl)
        DL_EMPTY: deadline_ms <= '1;
        DL_QUOT:  deadline_ms <= div_q[DL_W-1:0];
        default:  deadline_ms <= '0;
      endcase
    end
  end

  assign status = status_r;

  // ---------------------------------------------------------------- status
  assign stat.scan_done  = !scan_busy && !rd_pend;
  assign stat.found      = found;
  assign stat.min_due    = (best_exp <= now_r);
  assign stat.last_fire  = (fire_cnt == FIRE_CNT_W'(RESULT_CAP - 1)) ||
                           ((8'(fire_cnt) + 8'd1) == 8'(due_cnt));
  assign stat.cancel_hit = (tid_w < NUM_SLOTS) && vld[tid_idx];
  assign stat.div_done   = !div_busy;
  assign stat.out_free   = !rsp_valid || !rsp_stall;

endmodule

// ===== hdl/ttsch_ctrl.sv =====
// Controller state machine: sequences scans, commits, division and results.
// Depends on ttsch_pkg.
module ttsch_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [1:0]        kind,
  input  ttsch_pkg::stat_t  stat,
  output ttsch_pkg::cmd_t   cmd
);
  import ttsch_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADD_WR,
    S_CANCEL,
    S_FIRE_RD,
    S_FIRE_WR,
    S_DIV,
    S_EMIT
  } state_t;

  state_t      state;
  kind_t       kind_r;
  rsp_status_t res_status;
  id_sel_t     res_id;
  dl_sel_t     res_dl;
  logic        res_last;
  kind_t       kind_in;

  assign kind_in   = kind_t'(kind);
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.scan_mode  = SCAN_FREE;
    cmd.res_status = res_status;
    cmd.res_id     = res_id;
    cmd.res_dl     = res_dl;
    cmd.res_last   = res_last;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.load = 1'b1;
          case (kind_in)
            KIND_ADD: begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_FREE;
            end
            KIND_SCHED: begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_DUE_FIRST;
            end
            KIND_QUERY: begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_MIN;
            end
            default: cmd.scan_start = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        cmd.div_start = stat.scan_done && (kind_r == KIND_QUERY) &&
                        stat.found && !stat.min_due;
      end
      S_ADD_WR:  cmd.add_commit    = 1'b1;
      S_CANCEL:  cmd.cancel_commit = stat.cancel_hit;
      S_FIRE_WR: cmd.fire_commit   = 1'b1;
      S_EMIT: begin
        cmd.emit = stat.out_free;
        // more timers to fire: look for the next earliest
        if (stat.out_free && !res_last) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_DUE;
        end
      end
      default: cmd.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind_r     <= KIND_ADD;
      res_status <= ST_OK;
      res_id     <= ID_ZERO;
      res_dl     <= DL_ZERO;
      res_last   <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            kind_r <= kind_in;
            state  <= (kind_in == KIND_CANCEL) ? S_CANCEL : S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            res_id   <= ID_ZERO;
            res_dl   <= DL_ZERO;
            res_last <= 1'b1;
            case (kind_r)
              KIND_ADD: begin
                if (stat.found) begin
                  state <= S_ADD_WR;
                end else begin
                  res_status <= ST_FULL;
                  state      <= S_EMIT;
                end
              end
              KIND_SCHED: begin
                if (stat.found) begin
                  state <= S_FIRE_RD;
                end else begin
                  res_status <= ST_NONE_DUE;
                  state      <= S_EMIT;
                end
              end
              KIND_QUERY: begin
                res_status <= ST_OK;
                if (!stat.found) begin
                  res_dl <= DL_EMPTY;
                  state  <= S_EMIT;
                end else if (stat.min_due) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_DIV;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ADD_WR: begin
          res_status <= ST_OK;
          res_id     <= ID_BEST;
          res_dl     <= DL_ZERO;
          res_last   <= 1'b1;
          state      <= S_EMIT;
        end
        S_CANCEL: begin
          res_status <= stat.cancel_hit ? ST_OK : ST_NOT_FOUND;
          res_id     <= ID_TID;
          res_dl     <= DL_ZERO;
          res_last   <= 1'b1;
          state      <= S_EMIT;
        end
        S_FIRE_RD: state <= S_FIRE_WR;
        S_FIRE_WR: begin
          res_status <= ST_FIRED;
          res_id     <= ID_BEST;
          res_dl     <= DL_ZERO;
          res_last   <= stat.last_fire;
          state      <= S_EMIT;
        end
        S_DIV: begin
          if (stat.div_done) begin
            res_dl <= DL_QUOT;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= res_last ? S_IDLE : S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/timer_table_scheduler.sv =====
// Top level of the timer table scheduler: controller plus datapath.
// Depends on ttsch_pkg, ttsch_ctrl, ttsch_dp (and ttsch_ram below it).
//
// A table of MAX_TIMERS timer slots held in two small RAMs (expiration and
// interval, microseconds) with valid bits in flops. One command word is worked
// on at a time; cmd_stall is high until its last result word has been placed
// in the output register, so the next command is taken while that result
// waits. Every search is a scan that reads one slot per cycle from the
// expiration RAM. A query divides by 1000 when the earliest deadline lies in
// the future (in four 16-bit digits, each a multiply phase then a digit phase),
// and a schedule word fires its due timers one by one, with a rescan before
// each further timer, at most 16 fired per word. Results stay in the order
// they are produced; a stalled output holds the machine in place.
module timer_table_scheduler #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [1:0]                         kind,
  input  logic [ttsch_pkg::ID_W-1:0]         slot_id,
  input  logic [ttsch_pkg::TIME_W-1:0]       when,
  input  logic [ttsch_pkg::TIME_W-1:0]       interval,
  input  logic [ttsch_pkg::TIME_W-1:0]       now,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [2:0]                         status,
  output logic [ttsch_pkg::ID_W-1:0]         timer_id_res,
  output logic signed [ttsch_pkg::DL_W-1:0]  deadline_ms,
  output logic                               last
);
  import ttsch_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ttsch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .kind      (kind),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttsch_dp #(.MAX_TIMERS(MAX_TIMERS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .slot_id      (slot_id),
    .when         (when),
    .interval     (interval),
    .now          (now),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .timer_id_res (timer_id_res),
    .deadline_ms  (deadline_ms),
    .last         (last)
  );

endmodule

// ===== tb/sv/timer_table_checker.sv =====
// Scoreboard for the timer table scheduler: predicts result words per command.
// Depends on ttsch_pkg; instantiated beside the block by tb_timer_table_scheduler.
module timer_table_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  logic                               cmd_stall,
  input  logic [1:0]                         kind,
  input  logic [ttsch_pkg::ID_W-1:0]         slot_id,
  input  logic [ttsch_pkg::TIME_W-1:0]       when,
  input  logic [ttsch_pkg::TIME_W-1:0]       interval,
  input  logic [ttsch_pkg::TIME_W-1:0]       now,
  input  logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  logic [2:0]                         status,
  input  logic [ttsch_pkg::ID_W-1:0]         timer_id_res,
  input  logic signed [ttsch_pkg::DL_W-1:0]  deadline_ms,
  input  logic                               last,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttsch_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [2:0]               status;
    logic [ID_W-1:0]          id;
    logic signed [DL_W-1:0]   dl;
    logic                     last;
  } outcome_t;

  outcome_t          outcome_q[$];
  outcome_t          seen;
  outcome_t          want;
  logic              armed    [NUM_SLOTS];
  logic [TIME_W-1:0] fire_at  [NUM_SLOTS];
  logic [TIME_W-1:0] period   [NUM_SLOTS];
  int                n_bad = 0;

  function automatic void push_outcome(rsp_status_t st, logic [ID_W-1:0] id,
                                       logic signed [DL_W-1:0] dl, logic fin);
    outcome_t o;
    o.status = st;
    o.id     = id;
    o.dl     = dl;
    o.last   = fin;
    outcome_q.push_back(o);
  endfunction

  task automatic predict_word(input logic [1:0] op, input logic [ID_W-1:0] tid,
                              input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] iv,
                              input logic [TIME_W-1:0] t_now);
    int                best;
    int                fired;
    logic              due [NUM_SLOTS];
    logic [TIME_W:0]   sum;
    logic signed [DL_W-1:0] dl;
    outcome_t          tail;
    case (op)
      KIND_ADD: begin
        best = -1;
        for (int s = 0; s < NUM_SLOTS && best < 0; s++)
          if (!armed[s]) best = s;
        if (best < 0) begin
          push_outcome(ST_FULL, '0, '0, 1'b1);
        end else begin
          armed[best]   = 1'b1;
          fire_at[best] = w;
          period[best]  = iv;
          push_outcome(ST_OK, ID_W'(best), '0, 1'b1);
        end
      end
      KIND_CANCEL: begin
        if (int'(tid) < NUM_SLOTS && armed[tid]) begin
          armed[tid] = 1'b0;
          push_outcome(ST_OK, tid, '0, 1'b1);
        end else begin
          push_outcome(ST_NOT_FOUND, tid, '0, 1'b1);
        end
      end
      KIND_SCHED: begin
        // due set is frozen up front, so a re-armed timer cannot fire twice
        for (int s = 0; s < NUM_SLOTS; s++)
          due[s] = armed[s] && (fire_at[s] <= t_now);
        fired = 0;
        best  = 0;
        while (fired < RESULT_CAP && best >= 0) begin
          best = -1;
          for (int s = 0; s < NUM_SLOTS; s++)
            if (due[s] && (best < 0 || fire_at[s] < fire_at[best])) best = s;
          if (best >= 0) begin
            due[best] = 1'b0;
            if (period[best] != '0) begin
              sum = {1'b0, t_now} + {1'b0, period[best]};
              fire_at[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
              armed[best] = 1'b0;
            end
            push_outcome(ST_FIRED, ID_W'(best), '0, 1'b0);
            fired++;
          end
        end
        if (fired == 0) begin
          push_outcome(ST_NONE_DUE, '0, '0, 1'b1);
        end else begin
          tail = outcome_q.pop_back();
          tail.last = 1'b1;
          outcome_q.push_back(tail);
        end
      end
      default: begin
        best = -1;
        for (int s = 0; s < NUM_SLOTS; s++)
          if (armed[s] && (best < 0 || fire_at[s] < fire_at[best])) best = s;
        if (best < 0)
          dl = '1;
        else if (fire_at[best] <= t_now)
          dl = '0;
        else
          dl = DL_W'((fire_at[best] - t_now) / US_PER_MS);
        push_outcome(ST_OK, '0, dl, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) armed[s] = 1'b0;
      outcome_q.delete();
    end else begin
      if (cmd_valid && !cmd_stall)
        predict_word(kind, slot_id, when, interval, now);
      if (rsp_valid && !rsp_stall) begin
        seen.status = status;
        seen.id     = timer_id_res;
        seen.dl     = deadline_ms;
        seen.last   = last;
        if (outcome_q.size() == 0) begin
          if (n_bad < 10)
            $display("%t unexpected result word: status %0d id %0d dl %0d last %0b",
                     $realtime, seen.status, seen.id, seen.dl, seen.last);
          n_bad++;
        end else begin
          want = outcome_q.pop_front();
          if (seen !== want) begin
            if (n_bad < 10)
              $display({"%t mismatch: expected status %0d id %0d dl %0d last %0b,",
                        " got status %0d id %0d dl %0d last %0b"}, $realtime,
                       want.status, want.id, want.dl, want.last,
                       seen.status, seen.id, seen.dl, seen.last);
            n_bad++;
          end
        end
      end
    end
    fail_count <= n_bad;
    pending    <= outcome_q.size();
  end

endmodule

// ===== tb/sv/tb_timer_table_scheduler.sv =====
// Testbench top for the timer table scheduler: clock, reset, stimulus, verdict.
// Depends on ttsch_pkg, timer_table_scheduler and timer_table_checker.
module tb_timer_table_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import ttsch_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int RANDOM_WORDS = 70;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 120;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cmd_valid;
  logic                      cmd_stall;
  logic [1:0]                kind;
  logic [ID_W-1:0]           slot_id;
  logic [TIME_W-1:0]         when;
  logic [TIME_W-1:0]         interval;
  logic [TIME_W-1:0]         now;
  logic                      rsp_valid;
  logic                      rsp_stall;
  logic [2:0]                status;
  logic [ID_W-1:0]           timer_id_res;
  logic signed [DL_W-1:0]    deadline_ms;
  logic                      last;
  int                        fail_count;
  int                        pending;
  bit                        cmd_quiet = 1'b0;
  bit                        rsp_quiet = 1'b0;

  always #5 clk = ~clk;

  timer_table_scheduler #(.MAX_TIMERS(NUM_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .kind(kind), .slot_id(slot_id), .when(when), .interval(interval), .now(now),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .timer_id_res(timer_id_res), .deadline_ms(deadline_ms),
    .last(last)
  );

  timer_table_checker #(.NUM_SLOTS(NUM_SLOTS)) u_check (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .kind(kind), .slot_id(slot_id), .when(when), .interval(interval), .now(now),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .timer_id_res(timer_id_res), .deadline_ms(deadline_ms),
    .last(last), .fail_count(fail_count), .pending(pending)
  );

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  task automatic send_word(input kind_t k, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] iv,
                           input logic [TIME_W-1:0] t_now);
    int gap;
    gap = draw_gap(cmd_quiet);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    kind      <= k;
    slot_id   <= id;
    when      <= w;
    interval  <= iv;
    now       <= t_now;
    do @(posedge clk); while (cmd_stall);
  endtask

  // receiver back-pressure, drawn afresh for every result word
  initial begin
    int g;
    forever begin
      g = draw_gap(rsp_quiet);
      if (g > 0) begin
        rsp_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        idle = 0;
      else
        idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] clock_us;
    logic [TIME_W-1:0] w;
    logic [TIME_W-1:0] iv;
    logic [TIME_W-1:0] n;
    logic [ID_W-1:0]   id;
    int                pick;
    bit                noise;

    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    kind      <= KIND_ADD;
    slot_id   <= '0;
    when      <= '0;
    interval  <= '0;
    now       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table
    send_word(KIND_QUERY,  '0, '0, '0, '0);
    send_word(KIND_SCHED,  '0, '0, '0, '0);
    send_word(KIND_CANCEL, 4'd15, '0, '0, '0);
    // slots 0..4: one-shot at zero, far future, saturating repeat, a tie at 5 ms
    send_word(KIND_ADD, '0, '0, '0, '0);
    send_word(KIND_ADD, '0, TIME_MAX, TIME_MAX, '0);
    send_word(KIND_ADD, '0, 63'd1000, TIME_MAX, '0);
    send_word(KIND_ADD, '0, 63'd5000, '0, '0);
    send_word(KIND_ADD, '0, 63'd5000, 63'd3000, '0);
    send_word(KIND_QUERY, '0, '0, '0, '0);
    send_word(KIND_SCHED, '0, '0, '0, 63'd5000);
    send_word(KIND_QUERY, '0, '0, '0, 63'd1);
    send_word(KIND_CANCEL, 4'd1, '0, '0, '0);
    send_word(KIND_CANCEL, 4'd1, '0, '0, '0);
    // fill the table, overflow it, then fire everything in one word
    for (int i = 0; i < NUM_SLOTS - 2; i++)
      send_word(KIND_ADD, '0, rand_time(), (i < 3) ? rand_time() : '0, '0);
    send_word(KIND_ADD, '0, rand_time(), rand_time(), '0);
    send_word(KIND_SCHED, '0, '0, '0, TIME_MAX);
    send_word(KIND_QUERY, '0, '0, '0, '0);

    clock_us = '0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 20 == 0) begin
        cmd_quiet = ($urandom_range(0, 3) == 0);
        rsp_quiet = ($urandom_range(0, 3) == 0);
      end
      pick  = $urandom_range(0, 99);
      noise = ($urandom_range(0, 9) == 0);
      id    = ID_W'($urandom_range(0, 15));
      w     = rand_time();
      iv    = rand_time();
      n     = rand_time();
      if (pick < 35) begin
        if (!noise) begin
          w = clock_us + TIME_W'($urandom_range(0, 40000));
          if ($urandom_range(0, 2) == 0)
            iv = '0;
          else
            iv = TIME_W'($urandom_range(1, 25000));
        end
        send_word(KIND_ADD, id, w, iv, n);
      end else if (pick < 50) begin
        send_word(KIND_CANCEL, id, w, iv, n);
      end else if (pick < 80) begin
        if (!noise) begin
          clock_us = clock_us + TIME_W'($urandom_range(0, 30000));
          n = clock_us;
        end
        send_word(KIND_SCHED, id, w, iv, n);
      end else begin
        if (!noise) n = clock_us + TIME_W'($urandom_range(0, 20000));
        send_word(KIND_QUERY, id, w, iv, n);
      end
    end
    cmd_valid <= 1'b0;

    // wait so the pending count includes the last word's predictions
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ttsch_pkg.sv
hdl/ttsch_ram.sv
hdl/ttsch_dp.sv
hdl/ttsch_ctrl.sv
hdl/timer_table_scheduler.sv
tb/sv/timer_table_checker.sv
tb/sv/tb_timer_table_scheduler.sv
